>>> rtl/core/mpev_pkg.sv
package mpev_pkg;

   // width of the screen size registers
   localparam int CFG_SIZE_BITS = 13;

   // register reset values
   localparam logic [CFG_SIZE_BITS-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [CFG_SIZE_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd768;

   // register indexes on the configuration port
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // input item kinds
   typedef enum logic {
      OP_PACKET    = 1'b0,
      OP_BATCH_END = 1'b1
   } op_type;

   // result item kinds
   typedef enum logic {
      EVENT_MOVE  = 1'b0,
      EVENT_CLICK = 1'b1
   } event_kind_type;

   // status byte bit positions
   localparam int ST_LEFT    = 0;
   localparam int ST_RIGHT   = 1;
   localparam int ST_MIDDLE  = 2;
   localparam int ST_ONE     = 3;
   localparam int ST_X_SIGN  = 4;
   localparam int ST_Y_SIGN  = 5;
   localparam int ST_X_OVF   = 6;
   localparam int ST_Y_OVF   = 7;

   // number of buttons
   localparam int BUTTON_BITS = 3;

   // button codes in click events
   localparam logic [1:0] BUTTON_LEFT   = 2'd0;
   localparam logic [1:0] BUTTON_MIDDLE = 2'd1;
   localparam logic [1:0] BUTTON_RIGHT  = 2'd2;

endpackage

>>> rtl/core/mpev_queue.sv
module mpev_queue #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/mpev_front.sv
module mpev_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_op,
   input  logic [7:0]                         req_status,
   input  logic [7:0]                         req_move_x,
   input  logic [7:0]                         req_move_y,
   input  logic [mpev_pkg::CFG_SIZE_BITS-1:0] screen_width,
   input  logic [mpev_pkg::CFG_SIZE_BITS-1:0] screen_height,
   input  logic                               queue_full,
   output logic                               push,
   output logic [2*COORD_BITS+mpev_pkg::BUTTON_BITS-1:0] push_data
);

   localparam int CB   = COORD_BITS;
   localparam int BB   = mpev_pkg::BUTTON_BITS;
   localparam int CmpW = (CB + 1 > mpev_pkg::CFG_SIZE_BITS) ? CB + 1 : mpev_pkg::CFG_SIZE_BITS;

   logic [CB-1:0]   px_ff, px_in;
   logic [CB-1:0]   py_ff, py_in;
   logic [BB-1:0]   held_ff, held_in;
   logic [CB-1:0]   bsx_ff, bsx_in;
   logic [CB-1:0]   bsy_ff, bsy_in;

   logic            accept;
   logic            pkt_ok;
   logic [CmpW-1:0] full_w, wsize_w, hsize_w, xlim_w, ylim_w;
   logic [CB-1:0]   xlim, ylim;
   logic [CB+1:0]   dx_ext, dy_ext, sum_x, sum_y;
   logic [CB-1:0]   nx, ny;
   logic [BB-1:0]   new_btn, pressed;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   // screen limits: size zero acts as one, large sizes saturate
   always_comb begin
      full_w  = CmpW'(1) << CB;
      wsize_w = CmpW'(screen_width);
      hsize_w = CmpW'(screen_height);
      if (wsize_w == '0) begin
         xlim_w = '0;
      end else if (wsize_w > full_w) begin
         xlim_w = full_w - 1'b1;
      end else begin
         xlim_w = wsize_w - 1'b1;
      end
      if (hsize_w == '0) begin
         ylim_w = '0;
      end else if (hsize_w > full_w) begin
         ylim_w = full_w - 1'b1;
      end else begin
         ylim_w = hsize_w - 1'b1;
      end
      xlim = xlim_w[CB-1:0];
      ylim = ylim_w[CB-1:0];
   end

   // classify the packet and sign-extend the deltas
   assign pkt_ok = req_status[mpev_pkg::ST_ONE] && !req_status[mpev_pkg::ST_X_OVF]
                   && !req_status[mpev_pkg::ST_Y_OVF];
   assign dx_ext = {{(CB - 6){req_status[mpev_pkg::ST_X_SIGN]}}, req_move_x};
   assign dy_ext = {{(CB - 6){req_status[mpev_pkg::ST_Y_SIGN]}}, req_move_y};
   assign sum_x  = {2'b00, px_ff} + dx_ext;
   assign sum_y  = {2'b00, py_ff} - dy_ext;

   // clamp the new position to the screen
   always_comb begin
      if (sum_x[CB+1]) begin
         nx = '0;
      end else if (sum_x[CB:0] > {1'b0, xlim}) begin
         nx = xlim;
      end else begin
         nx = sum_x[CB-1:0];
      end
      if (sum_y[CB+1]) begin
         ny = '0;
      end else if (sum_y[CB:0] > {1'b0, ylim}) begin
         ny = ylim;
      end else begin
         ny = sum_y[CB-1:0];
      end
   end

   assign new_btn = req_status[BB-1:0];
   assign pressed = new_btn & ~held_ff;

   // update pointer state and hand a job to the queue
   always_comb begin
      px_in     = px_ff;
      py_in     = py_ff;
      held_in   = held_ff;
      bsx_in    = bsx_ff;
      bsy_in    = bsy_ff;
      push      = 1'b0;
      push_data = {px_ff, py_ff, {BB{1'b0}}};
      if (accept) begin
         unique case (mpev_pkg::op_type'(req_op))
            mpev_pkg::OP_BATCH_END: begin
               bsx_in = px_ff;
               bsy_in = py_ff;
               push   = (px_ff != bsx_ff) || (py_ff != bsy_ff);
            end
            mpev_pkg::OP_PACKET: begin
               if (pkt_ok) begin
                  px_in     = nx;
                  py_in     = ny;
                  held_in   = new_btn;
                  push      = (pressed != '0);
                  push_data = {nx, ny, pressed};
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff   <= '0;
         py_ff   <= '0;
         held_ff <= '0;
         bsx_ff  <= '0;
         bsy_ff  <= '0;
      end else begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         held_ff <= held_in;
         bsx_ff  <= bsx_in;
         bsy_ff  <= bsy_in;
      end
   end

endmodule

>>> rtl/core/mpev_back.sv
module mpev_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  logic [2*COORD_BITS+mpev_pkg::BUTTON_BITS-1:0] job_data,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mpev_pkg::event_kind_type rsp_kind,
   output logic [COORD_BITS-1:0] rsp_event_a,
   output logic [COORD_BITS-1:0] rsp_event_b,
   output logic                  rsp_tlast
);

   localparam int CB = COORD_BITS;
   localparam int BB = mpev_pkg::BUTTON_BITS;

   logic                     valid_ff, valid_in;
   mpev_pkg::event_kind_type kind_ff, kind_in;
   logic [CB-1:0]            a_ff, a_in;
   logic [CB-1:0]            b_ff, b_in;
   logic                     last_ff, last_in;
   logic [BB-1:0]            pend_ff, pend_in;

   logic                     load;
   logic [CB-1:0]            job_x, job_y;
   logic [BB-1:0]            job_pressed;
   logic [1:0]               btn_code;
   logic [BB-1:0]            pend_left;

   assign job_x       = job_data[2*CB+BB-1:CB+BB];
   assign job_y       = job_data[CB+BB-1:BB];
   assign job_pressed = job_data[BB-1:0];
   assign load        = !valid_ff || rsp_tready;

   // pick the next click: left, then middle, then right
   always_comb begin
      pend_left = pend_ff;
      priority if (pend_ff[mpev_pkg::ST_LEFT]) begin
         btn_code                        = mpev_pkg::BUTTON_LEFT;
         pend_left[mpev_pkg::ST_LEFT]    = 1'b0;
      end else if (pend_ff[mpev_pkg::ST_MIDDLE]) begin
         btn_code                        = mpev_pkg::BUTTON_MIDDLE;
         pend_left[mpev_pkg::ST_MIDDLE]  = 1'b0;
      end else begin
         btn_code                        = mpev_pkg::BUTTON_RIGHT;
         pend_left[mpev_pkg::ST_RIGHT]   = 1'b0;
      end
   end

   // refill the output beat: pending clicks first, then the next job's move
   always_comb begin
      valid_in = valid_ff;
      kind_in  = kind_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      last_in  = last_ff;
      pend_in  = pend_ff;
      pop      = 1'b0;
      if (load) begin
         if (pend_ff != '0) begin
            valid_in = 1'b1;
            kind_in  = mpev_pkg::EVENT_CLICK;
            a_in     = CB'(btn_code);
            b_in     = '0;
            last_in  = (pend_left == '0);
            pend_in  = pend_left;
         end else if (job_valid) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            kind_in  = mpev_pkg::EVENT_MOVE;
            a_in     = job_x;
            b_in     = job_y;
            last_in  = (job_pressed == '0);
            pend_in  = job_pressed;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   // hold the beat payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_kind    = kind_ff;
   assign rsp_event_a = a_ff;
   assign rsp_event_b = b_ff;
   assign rsp_tlast   = last_ff;

endmodule

>>> rtl/core/mouse_packet_event_generator.sv
// Turns PS/2 mouse packets and batch-end markers into move and click events.
// The front end accepts one item per cycle whenever the job queue has room: it
// checks the packet (always-one bit set, no overflow), moves the pointer by the
// sign-extended deltas (y inverted), clamps to screen_width-1 / screen_height-1,
// and queues a job when a button is newly pressed or, at a batch end, when the
// pointer moved since the previous batch end. The back end drains the queue
// through a registered output, one event per cycle while rsp_tready does not
// hold it off: a job yields a move event and then one click per new press
// (left, middle, right). Sustained throughput is set by that output stage;
// QUEUE_DEPTH jobs can wait while the output is stalled. Configuration is
// written through the APB-style port: width at byte 0, height at byte 4.
module mouse_packet_event_generator #(
   parameter int COORD_BITS  = 12,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] status_byte, [15:8] move_x, [23:16] move_y
   input  logic [23:0]           req_tdata,
   // [0] op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [COORD_BITS-1:0] event_a, [2*COORD_BITS-1:COORD_BITS] event_b, zero fill
   output logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // [0] event_kind
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CB   = COORD_BITS;
   localparam int JobW = 2 * CB + mpev_pkg::BUTTON_BITS;
   localparam int TdW  = ((2 * CB + 7) / 8) * 8;
   localparam int SW   = mpev_pkg::CFG_SIZE_BITS;

   logic [SW-1:0]            width_ff, width_in;
   logic [SW-1:0]            height_ff, height_in;
   logic                     cfg_write;
   logic                     push, pop, full, empty;
   logic [JobW-1:0]          push_data, head_data;
   mpev_pkg::event_kind_type rsp_kind;
   logic [CB-1:0]            rsp_event_a, rsp_event_b;

   // configuration registers
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            mpev_pkg::REG_SCREEN_WIDTH:  width_in  = csr_pwdata[SW-1:0];
            mpev_pkg::REG_SCREEN_HEIGHT: height_in = csr_pwdata[SW-1:0];
            default:                     width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         mpev_pkg::REG_SCREEN_WIDTH:  csr_prdata = 32'(width_ff);
         mpev_pkg::REG_SCREEN_HEIGHT: csr_prdata = 32'(height_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mpev_pkg::SCREEN_WIDTH_RESET;
         height_ff <= mpev_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // classify items and track the pointer
   mpev_front #(
      .COORD_BITS (CB)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_op        (req_tuser),
      .req_status    (req_tdata[7:0]),
      .req_move_x    (req_tdata[15:8]),
      .req_move_y    (req_tdata[23:16]),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .queue_full    (full),
      .push          (push),
      .push_data     (push_data)
   );

   // jobs waiting for the output
   mpev_queue #(
      .WIDTH (JobW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .full      (full),
      .empty     (empty)
   );

   // expand jobs into events
   mpev_back #(
      .COORD_BITS (CB)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (!empty),
      .job_data    (head_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_event_a (rsp_event_a),
      .rsp_event_b (rsp_event_b),
      .rsp_tlast   (rsp_tlast)
   );

   assign rsp_tdata = TdW'({rsp_event_b, rsp_event_a});
   assign rsp_tuser = rsp_kind;

endmodule

>>> tb/mpev_checker.sv
`timescale 1ns / 100ps

// Watches the packet, event and register ports of the event generator, keeps
// its own copy of the pointer state and screen size, and compares every event
// beat against the events that the accepted packets and batch ends call for.
module mpev_checker
   import mpev_pkg::*;
#(
   parameter int COORD_BITS = 12,
   parameter int RSP_BITS   = ((2*COORD_BITS+7)/8)*8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_BITS-1:0] rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                rsp_tlast,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   input  logic                csr_pready,
   output int                  fail_count,
   output int                  pending_events
);

   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      event_kind_type kind;
      coord_type      a;
      coord_type      b;
      logic           last;
   } mouse_event_type;

   coord_type                ptr_x;
   coord_type                ptr_y;
   coord_type                mark_x;
   coord_type                mark_y;
   logic [BUTTON_BITS-1:0]   held;
   logic [CFG_SIZE_BITS-1:0] width_cfg;
   logic [CFG_SIZE_BITS-1:0] height_cfg;
   mouse_event_type          due_events[$];
   mouse_event_type          want;
   int                       fails;

   // largest coordinate on a screen of the given size
   function automatic int size_limit(input logic [CFG_SIZE_BITS-1:0] size);
      if (size == '0) return 0;
      if (int'(size) > COORD_MAX + 1) return COORD_MAX;
      return int'(size) - 1;
   endfunction

   function automatic coord_type clamp_coord(input int pos, input int lim);
      if (pos < 0) return '0;
      if (pos > lim) return coord_type'(lim);
      return coord_type'(pos);
   endfunction

   function automatic mouse_event_type make_event(input event_kind_type kind,
                                                  input coord_type a, input coord_type b);
      mouse_event_type ev;
      ev.kind = kind;
      ev.a    = a;
      ev.b    = b;
      ev.last = 1'b0;
      return ev;
   endfunction

   // Update the pointer copy for one accepted beat and queue the events it causes.
   function automatic void track_mouse_item(input op_type op, input logic [7:0] st,
                                            input logic [7:0] mx, input logic [7:0] my);
      mouse_event_type        burst[$];
      mouse_event_type        ev;
      logic [BUTTON_BITS-1:0] fresh;
      int                     dx;
      int                     dy;
      if (op == OP_BATCH_END) begin
         // report a move only if the pointer left its spot at the previous batch end
         if (ptr_x != mark_x || ptr_y != mark_y)
            burst.push_back(make_event(EVENT_MOVE, ptr_x, ptr_y));
         mark_x = ptr_x;
         mark_y = ptr_y;
      end else if (st[ST_ONE] && !st[ST_X_OVF] && !st[ST_Y_OVF]) begin
         // sign-extend the deltas; y grows downward on screen
         dx = int'(mx) - (st[ST_X_SIGN] ? 256 : 0);
         dy = int'(my) - (st[ST_Y_SIGN] ? 256 : 0);
         ptr_x = clamp_coord(int'(ptr_x) + dx, size_limit(width_cfg));
         ptr_y = clamp_coord(int'(ptr_y) - dy, size_limit(height_cfg));
         fresh = st[BUTTON_BITS-1:0] & ~held;
         held  = st[BUTTON_BITS-1:0];
         if (fresh != '0) begin
            burst.push_back(make_event(EVENT_MOVE, ptr_x, ptr_y));
            if (fresh[ST_LEFT])
               burst.push_back(make_event(EVENT_CLICK, coord_type'(BUTTON_LEFT), '0));
            if (fresh[ST_MIDDLE])
               burst.push_back(make_event(EVENT_CLICK, coord_type'(BUTTON_MIDDLE), '0));
            if (fresh[ST_RIGHT])
               burst.push_back(make_event(EVENT_CLICK, coord_type'(BUTTON_RIGHT), '0));
         end
      end
      // flag the closing event of this input
      foreach (burst[i]) begin
         ev      = burst[i];
         ev.last = (i == burst.size() - 1);
         due_events.push_back(ev);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         ptr_x      = '0;
         ptr_y      = '0;
         mark_x     = '0;
         mark_y     = '0;
         held       = '0;
         width_cfg  = SCREEN_WIDTH_RESET;
         height_cfg = SCREEN_HEIGHT_RESET;
         fails      = 0;
         due_events.delete();
      end else begin
         // follow register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {REG_SCREEN_WIDTH, 2'b00})
               width_cfg = csr_pwdata[CFG_SIZE_BITS-1:0];
            else if (csr_paddr == {REG_SCREEN_HEIGHT, 2'b00})
               height_cfg = csr_pwdata[CFG_SIZE_BITS-1:0];
         end
         // match the event beat against the oldest waiting event
         if (rsp_tvalid && rsp_tready) begin
            if (due_events.size() == 0) begin
               fails++;
               $display({"%0t: unexpected event: expected none,",
                         " got kind %0d a %0d b %0d last %0d"},
                        $time, rsp_tuser, rsp_tdata[COORD_BITS-1:0],
                        rsp_tdata[2*COORD_BITS-1:COORD_BITS], rsp_tlast);
            end else begin
               want = due_events.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[COORD_BITS-1:0] !== want.a ||
                   rsp_tdata[2*COORD_BITS-1:COORD_BITS] !== want.b ||
                   rsp_tlast !== want.last) begin
                  fails++;
                  $display({"%0t: event mismatch: expected kind %0d a %0d b %0d last %0d,",
                            " got kind %0d a %0d b %0d last %0d"},
                           $time, want.kind, want.a, want.b, want.last, rsp_tuser,
                           rsp_tdata[COORD_BITS-1:0],
                           rsp_tdata[2*COORD_BITS-1:COORD_BITS], rsp_tlast);
               end
            end
         end
         // predict from the accepted input beat
         if (req_tvalid && req_tready)
            track_mouse_item(op_type'(req_tuser), req_tdata[7:0], req_tdata[15:8],
                             req_tdata[23:16]);
      end
      fail_count     <= fails;
      pending_events <= due_events.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import mpev_pkg::*;

   localparam int COORD_BITS    = 12;
   localparam int RSP_BITS      = ((2*COORD_BITS+7)/8)*8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_GAP       = 32;
   localparam int PHASES        = 9;
   localparam int PHASE_ITEMS   = 56;

   localparam logic [BUTTON_BITS-1:0] NO_BTNS    = '0;
   localparam logic [BUTTON_BITS-1:0] LEFT_BTN   = BUTTON_BITS'(1 << ST_LEFT);
   localparam logic [BUTTON_BITS-1:0] RIGHT_BTN  = BUTTON_BITS'(1 << ST_RIGHT);
   localparam logic [BUTTON_BITS-1:0] MIDDLE_BTN = BUTTON_BITS'(1 << ST_MIDDLE);
   localparam logic [BUTTON_BITS-1:0] ALL_BTNS   = LEFT_BTN | RIGHT_BTN | MIDDLE_BTN;

   localparam logic [7:0] ONE_BIT   = 8'(1 << ST_ONE);
   localparam logic [7:0] X_OVF_BIT = 8'(1 << ST_X_OVF);
   localparam logic [7:0] Y_OVF_BIT = 8'(1 << ST_Y_OVF);

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   // [7:0] status_byte, [15:8] move_x, [23:16] move_y
   logic [23:0]         req_tdata;
   // [0] op
   logic                req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   // [11:0] event_a, [23:12] event_b
   logic [RSP_BITS-1:0] rsp_tdata;
   // [0] event_kind
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [2:0]          csr_paddr;
   logic [31:0]         csr_pwdata;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   int   fail_count;
   int   pending_events;
   int   send_idle_pct;
   int   stall_pct;
   logic hold_request;
   logic hold_done;

   mouse_packet_event_generator #(
      .COORD_BITS (COORD_BITS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mpev_checker #(
      .COORD_BITS (COORD_BITS),
      .RSP_BITS   (RSP_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .pending_events (pending_events)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // give up on a hung run
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

   // Event side: random stalls, plus one long hold-off on request.
   initial begin : event_sink
      hold_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [7:0] make_status(input logic [BUTTON_BITS-1:0] buttons,
                                              input logic x_neg, input logic y_neg);
      logic [7:0] st;
      st                   = '0;
      st[BUTTON_BITS-1:0]  = buttons;
      st[ST_ONE]           = 1'b1;
      st[ST_X_SIGN]        = x_neg;
      st[ST_Y_SIGN]        = y_neg;
      return st;
   endfunction

   // nine-bit delta, leaning hard one way when a drift is given
   function automatic logic [8:0] random_delta(input int drift);
      int d;
      if (drift > 0 && $urandom_range(99) < 80)
         d = int'($urandom_range(255, 96));
      else if (drift < 0 && $urandom_range(99) < 80)
         d = -int'($urandom_range(256, 96));
      else
         d = int'($urandom_range(511)) - 256;
      return 9'(d);
   endfunction

   // Offer one beat after a random idle gap and hold it until accepted.
   task automatic send_item(input op_type op, input logic [7:0] st, input logic [7:0] mx,
                            input logic [7:0] my);
      int gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {my, mx, st};
      do @(posedge clock); while (!req_tready);
   endtask

   // Mostly well-formed packets with random content; some batch ends and noise.
   task automatic random_item(input int x_drift, input int y_drift);
      logic [BUTTON_BITS-1:0] buttons;
      logic [8:0]             dx;
      logic [8:0]             dy;
      int                     pick;
      pick    = $urandom_range(99);
      buttons = ($urandom_range(99) < 35) ? NO_BTNS : BUTTON_BITS'($urandom_range(7));
      dx      = random_delta(x_drift);
      // screen y runs opposite to the wire delta
      dy      = random_delta(-y_drift);
      if (pick < 15)
         send_item(OP_BATCH_END, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 27)
         send_item(OP_PACKET, 8'($urandom), 8'($urandom), 8'($urandom));
      else
         send_item(OP_PACKET, make_status(buttons, dx[8], dy[8]), dx[7:0], dy[7:0]);
   endtask

   // Drop valid, wait for every event to drain, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_events != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [CFG_SIZE_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_SIZE_BITS-1:0] width_val;
      logic [CFG_SIZE_BITS-1:0] height_val;
      int                       x_drift;
      int                       y_drift;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tuser    <= OP_PACKET;
      req_tdata    <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      hold_request <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on the reset screen size
      send_item(OP_BATCH_END, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b0, 1'b1), 8'hFF, 8'h00);
      send_item(OP_PACKET, make_status(LEFT_BTN, 1'b0, 1'b0), 8'h00, 8'h00);
      send_item(OP_PACKET, make_status(ALL_BTNS, 1'b0, 1'b0), 8'h00, 8'h00);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      // broken packets must leave position and buttons alone
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b0, 1'b0) & ~ONE_BIT, 8'h7F, 8'h7F);
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b1, 1'b1) | X_OVF_BIT, 8'h80, 8'h80);
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b1, 1'b1) | Y_OVF_BIT, 8'h80, 8'h80);
      // still held, so no events while clamping at the left and top edges; then release and press all again
      send_item(OP_PACKET, make_status(ALL_BTNS, 1'b1, 1'b0), 8'h00, 8'hFF);
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b0, 1'b0), 8'h00, 8'hFF);
      send_item(OP_PACKET, make_status(ALL_BTNS, 1'b0, 1'b0), 8'h00, 8'h00);
      // walk to the bottom-right corner and clamp there
      repeat (5) send_item(OP_PACKET, make_status(NO_BTNS, 1'b0, 1'b1), 8'hFF, 8'h00);
      send_item(OP_PACKET, make_status(RIGHT_BTN, 1'b0, 1'b0), 8'h00, 8'h00);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      drain();

      // zero and one pixel screens: pointer stays outside until the next packet
      write_reg(REG_SCREEN_WIDTH, 13'd1);
      write_reg(REG_SCREEN_HEIGHT, 13'd0);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      send_item(OP_PACKET, make_status(MIDDLE_BTN, 1'b0, 1'b0), 8'h00, 8'h00);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      send_item(OP_PACKET, make_status(NO_BTNS, 1'b0, 1'b1), 8'h01, 8'hFF);
      send_item(OP_BATCH_END, 8'h00, 8'h00, 8'h00);
      drain();

      // hold off the event side so the job queue fills and stalls the input
      write_reg(REG_SCREEN_WIDTH, 13'd640);
      write_reg(REG_SCREEN_HEIGHT, 13'd480);
      hold_request <= 1'b1;
      for (int i = 0; i < 24; i++)
         send_item(OP_PACKET, make_status((i % 2) ? NO_BTNS : ALL_BTNS, 1'b0, 1'b0),
                   8'($urandom_range(127)), 8'($urandom_range(127)));
      hold_request <= 1'b0;
      drain();

      // random phases over screen sizes and idle patterns
      for (int p = 0; p < PHASES; p++) begin
         x_drift = int'($urandom_range(2)) - 1;
         y_drift = int'($urandom_range(2)) - 1;
         case (p % 3)
            0: begin
               width_val  = 13'($urandom_range(4096, 1));
               height_val = 13'($urandom_range(4096, 1));
            end
            1: begin
               width_val  = 13'($urandom_range(48, 1));
               height_val = 13'($urandom_range(48, 0));
            end
            default: begin
               // oversized screens saturate at the coordinate range
               width_val  = (p == 2) ? 13'h1FFF : 13'($urandom_range(8191, 4096));
               height_val = (p == 2) ? 13'd4096 : 13'h1FFF;
               x_drift    = (p == 5) ? -1 : 1;
               y_drift    = x_drift;
            end
         endcase
         write_reg(REG_SCREEN_WIDTH, width_val);
         write_reg(REG_SCREEN_HEIGHT, height_val);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 73; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 73; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         repeat (PHASE_ITEMS) random_item(x_drift, y_drift);
         drain();
      end

      if (fail_count == 0 && pending_events == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
